[rtl/calendar_date_time_to_ticks_unit_assert.svh]
// assertion macros used by the date and time conversion rtl
`ifndef CALENDAR_DATE_TIME_TO_TICKS_UNIT_ASSERT_SVH
`define CALENDAR_DATE_TIME_TO_TICKS_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CDTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CDTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cdtt_pkg.sv]
package cdtt_pkg;

  // field widths
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int MS_W   = 10;
  localparam int DN_W   = 22;
  localparam int DT_W   = 62;
  localparam int TT_W   = 41;
  localparam int DBM_W  = 9;
  localparam int Q100_W = 8;

  // word layout
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 3;

  // calendar and clock constants
  localparam int TICKS_PER_MS  = 10000;
  localparam int MS_PER_SEC    = 1000;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOUR_PER_DAY  = 24;
  localparam int MAX_YEAR      = 9999;
  localparam int MONTHS        = 12;
  localparam int DAYS_PER_YEAR = 365;
  localparam int MAX_DAY_NUMBER = 3652058;

  // divide by 100 as multiply by reciprocal, exact for any 14-bit value
  localparam int RECIP_100    = 5243;
  localparam int RECIP_SHIFT  = 19;
  localparam int RECIP_PROD_W = 27;

  localparam longint TICKS_SEC_L  = longint'(MS_PER_SEC) * longint'(TICKS_PER_MS);
  localparam longint TICKS_MIN_L  = TICKS_SEC_L * longint'(SEC_PER_MIN);
  localparam longint TICKS_HOUR_L = TICKS_MIN_L * longint'(MIN_PER_HOUR);
  localparam longint TICKS_DAY_L  = TICKS_HOUR_L * longint'(HOUR_PER_DAY);

  localparam logic [TT_W-1:0] TICKS_MS   = TT_W'(TICKS_PER_MS);
  localparam logic [TT_W-1:0] TICKS_SEC  = TT_W'(TICKS_SEC_L);
  localparam logic [TT_W-1:0] TICKS_MIN  = TT_W'(TICKS_MIN_L);
  localparam logic [TT_W-1:0] TICKS_HOUR = TT_W'(TICKS_HOUR_L);

  // ticks per day split into a 32-bit low part and a narrow high part
  localparam int DAY_LO_W = 32;
  localparam int DAY_HI_W = 8;
  localparam logic [DAY_LO_W-1:0] TICKS_DAY_LO = DAY_LO_W'(TICKS_DAY_L);
  localparam logic [DAY_HI_W-1:0] TICKS_DAY_HI = DAY_HI_W'(TICKS_DAY_L >>> DAY_LO_W);

  // days in the year up to the end of a month, month 0 stands for no days
  function automatic logic [DBM_W-1:0] days_before(input logic leap_yr,
                                                   input logic [MON_W-1:0] mon);
    logic [DBM_W-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap_yr ? 9'd60  : 9'd59;
      4'd3:    d = leap_yr ? 9'd91  : 9'd90;
      4'd4:    d = leap_yr ? 9'd121 : 9'd120;
      4'd5:    d = leap_yr ? 9'd152 : 9'd151;
      4'd6:    d = leap_yr ? 9'd182 : 9'd181;
      4'd7:    d = leap_yr ? 9'd213 : 9'd212;
      4'd8:    d = leap_yr ? 9'd244 : 9'd243;
      4'd9:    d = leap_yr ? 9'd274 : 9'd273;
      4'd10:   d = leap_yr ? 9'd305 : 9'd304;
      4'd11:   d = leap_yr ? 9'd335 : 9'd334;
      4'd12:   d = leap_yr ? 9'd366 : 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/calendar_date_time_to_ticks_unit.sv]
// Gregorian date and time of day to tick counts (one tick = 1/10000 ms).
// Input channel in_*: one word per timestamp, fields in in_tdata.
// Result channel out_*: one word per input word, in the same order, with
// day count, date ticks and time ticks in out_tdata and the date valid,
// time valid and leap year flags in out_tuser.
// From input accept to out_tvalid a word passes five registered stages: input
// multiply, calendar checks and year terms, day count sum, the two partial
// products of the date tick multiply, and the final add into the output register.
// Throughput is one word per cycle while out_tready is high; each stage has
// its own valid bit and loads whenever the stage after it is empty or moving,
// so bubbles close up while the receiver stalls.
// When out_tready is low the output word holds; in_tready drops only once
// all five stages hold words.
// Reset clears every valid bit; the pipeline is empty and ready in the
// first cycle after rst_n rises. No state is kept between words.
`include "calendar_date_time_to_ticks_unit_assert.svh"

module calendar_date_time_to_ticks_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year[13:0] month[17:14] day_of_month[22:18] hour[27:23] minute[33:28]
  // second[39:34] milli[49:40], zero fill above
  input  logic [cdtt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // day_number[21:0] date_ticks[83:22] time_ticks[124:84], zero fill above
  output logic [cdtt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // date_ok[0] time_ok[1] leap[2]
  output logic [cdtt_pkg::OUT_USER_W-1:0]     out_tuser
);

  // unpacked input fields
  logic [cdtt_pkg::YEAR_W-1:0] in_year;
  logic [cdtt_pkg::MON_W-1:0]  in_month;
  logic [cdtt_pkg::DAY_W-1:0]  in_day;
  logic [cdtt_pkg::HOUR_W-1:0] in_hour;
  logic [cdtt_pkg::MIN_W-1:0]  in_minute;
  logic [cdtt_pkg::SEC_W-1:0]  in_second;
  logic [cdtt_pkg::MS_W-1:0]   in_milli;

  assign in_year   = in_tdata[13:0];
  assign in_month  = in_tdata[17:14];
  assign in_day    = in_tdata[22:18];
  assign in_hour   = in_tdata[27:23];
  assign in_minute = in_tdata[33:28];
  assign in_second = in_tdata[39:34];
  assign in_milli  = in_tdata[49:40];

  // stage valids and load enables
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !s5_vld_r || out_tready;
  assign en4 = !s4_vld_r || en5;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_tvalid;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
      if (en4) s4_vld_r <= s3_vld_r;
      if (en5) s5_vld_r <= s4_vld_r;
    end
  end

  // stage 1: year quotients by 100, time checks and time partial products
  logic [cdtt_pkg::YEAR_W-1:0]       y1_nxt;
  logic [cdtt_pkg::RECIP_PROD_W-1:0] y1_prod, yr_prod;
  logic                              time_ok_nxt;
  logic [cdtt_pkg::TT_W-1:0]         th_nxt, tm_nxt, ts_nxt, tms_nxt;

  assign y1_nxt  = in_year - cdtt_pkg::YEAR_W'(1);
  assign y1_prod = cdtt_pkg::RECIP_PROD_W'(y1_nxt) *
                   cdtt_pkg::RECIP_PROD_W'(cdtt_pkg::RECIP_100);
  assign yr_prod = cdtt_pkg::RECIP_PROD_W'(in_year) *
                   cdtt_pkg::RECIP_PROD_W'(cdtt_pkg::RECIP_100);

  assign time_ok_nxt = (in_hour < cdtt_pkg::HOUR_W'(cdtt_pkg::HOUR_PER_DAY)) &&
                       (in_minute < cdtt_pkg::MIN_W'(cdtt_pkg::MIN_PER_HOUR)) &&
                       (in_second < cdtt_pkg::SEC_W'(cdtt_pkg::SEC_PER_MIN)) &&
                       (in_milli < cdtt_pkg::MS_W'(cdtt_pkg::MS_PER_SEC));
  assign th_nxt  = cdtt_pkg::TT_W'(in_hour) * cdtt_pkg::TICKS_HOUR;
  assign tm_nxt  = cdtt_pkg::TT_W'(in_minute) * cdtt_pkg::TICKS_MIN;
  assign ts_nxt  = cdtt_pkg::TT_W'(in_second) * cdtt_pkg::TICKS_SEC;
  assign tms_nxt = cdtt_pkg::TT_W'(in_milli) * cdtt_pkg::TICKS_MS;

  logic [cdtt_pkg::YEAR_W-1:0] s1_year_r, s1_y1_r;
  logic [cdtt_pkg::Q100_W-1:0] s1_qy_r, s1_q1_r;
  logic [cdtt_pkg::MON_W-1:0]  s1_month_r;
  logic [cdtt_pkg::DAY_W-1:0]  s1_day_r;
  logic                        s1_time_ok_r;
  logic [cdtt_pkg::TT_W-1:0]   s1_th_r, s1_tm_r, s1_ts_r, s1_tms_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year_r    <= in_year;
      s1_y1_r      <= y1_nxt;
      s1_qy_r      <= yr_prod[cdtt_pkg::RECIP_PROD_W-1:cdtt_pkg::RECIP_SHIFT];
      s1_q1_r      <= y1_prod[cdtt_pkg::RECIP_PROD_W-1:cdtt_pkg::RECIP_SHIFT];
      s1_month_r   <= in_month;
      s1_day_r     <= in_day;
      s1_time_ok_r <= time_ok_nxt;
      s1_th_r      <= th_nxt;
      s1_tm_r      <= tm_nxt;
      s1_ts_r      <= ts_nxt;
      s1_tms_r     <= tms_nxt;
    end
  end

  // stage 2: leap rule, month table, date check, year terms, time sum
  logic                         year_ok, month_ok, day_ok, leap_nxt, date_ok_nxt;
  logic [cdtt_pkg::YEAR_W-1:0]  rem100;
  logic [cdtt_pkg::DBM_W-1:0]   dbm_pre, dbm_end;
  logic [cdtt_pkg::DBM_W:0]     day_end;
  logic [cdtt_pkg::DN_W-1:0]    yd_nxt, corr_nxt;
  logic [cdtt_pkg::DBM_W-1:0]   mday_nxt;
  logic [cdtt_pkg::TT_W-1:0]    tt_nxt;

  assign year_ok = (s1_year_r != '0) &&
                   (s1_year_r <= cdtt_pkg::YEAR_W'(cdtt_pkg::MAX_YEAR));
  assign rem100  = s1_year_r - cdtt_pkg::YEAR_W'(s1_qy_r) * cdtt_pkg::YEAR_W'(100);
  // an out-of-range year is never treated as leap
  assign leap_nxt = year_ok && (s1_year_r[1:0] == 2'b00) &&
                    ((rem100 != '0) || (s1_qy_r[1:0] == 2'b00));
  assign month_ok = (s1_month_r != '0) &&
                    (s1_month_r <= cdtt_pkg::MON_W'(cdtt_pkg::MONTHS));
  assign dbm_pre  = cdtt_pkg::days_before(leap_nxt, s1_month_r - cdtt_pkg::MON_W'(1));
  assign dbm_end  = cdtt_pkg::days_before(leap_nxt, s1_month_r);
  assign day_end  = {1'b0, dbm_pre} + (cdtt_pkg::DBM_W + 1)'(s1_day_r);
  assign day_ok   = (s1_day_r != '0) && (day_end <= {1'b0, dbm_end});
  assign date_ok_nxt = year_ok && month_ok && day_ok;

  assign yd_nxt   = cdtt_pkg::DN_W'(s1_y1_r) * cdtt_pkg::DN_W'(cdtt_pkg::DAYS_PER_YEAR);
  assign corr_nxt = cdtt_pkg::DN_W'(s1_y1_r >> 2) - cdtt_pkg::DN_W'(s1_q1_r) +
                    cdtt_pkg::DN_W'(s1_q1_r >> 2);
  assign mday_nxt = dbm_pre + cdtt_pkg::DBM_W'(s1_day_r) - cdtt_pkg::DBM_W'(1);

  assign tt_nxt = s1_time_ok_r ? (s1_th_r + s1_tm_r + s1_ts_r + s1_tms_r) : '1;

  logic                       s2_date_ok_r, s2_time_ok_r, s2_leap_r;
  logic [cdtt_pkg::DN_W-1:0]  s2_yd_r, s2_corr_r;
  logic [cdtt_pkg::DBM_W-1:0] s2_mday_r;
  logic [cdtt_pkg::TT_W-1:0]  s2_tt_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_date_ok_r <= date_ok_nxt;
      s2_time_ok_r <= s1_time_ok_r;
      s2_leap_r    <= leap_nxt;
      s2_yd_r      <= yd_nxt;
      s2_corr_r    <= corr_nxt;
      s2_mday_r    <= mday_nxt;
      s2_tt_r      <= tt_nxt;
    end
  end

  // stage 3: day count, zero for a bad date
  logic [cdtt_pkg::DN_W-1:0] dn_nxt;

  assign dn_nxt = s2_date_ok_r ?
                  (s2_yd_r + s2_corr_r + cdtt_pkg::DN_W'(s2_mday_r)) : '0;

  logic                      s3_date_ok_r, s3_time_ok_r, s3_leap_r;
  logic [cdtt_pkg::DN_W-1:0] s3_dn_r;
  logic [cdtt_pkg::TT_W-1:0] s3_tt_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_date_ok_r <= s2_date_ok_r;
      s3_time_ok_r <= s2_time_ok_r;
      s3_leap_r    <= s2_leap_r;
      s3_dn_r      <= dn_nxt;
      s3_tt_r      <= s2_tt_r;
    end
  end

  // stage 4: partial products of day count times ticks per day
  localparam int PP_LO_W = cdtt_pkg::DN_W + cdtt_pkg::DAY_LO_W;
  localparam int PP_HI_W = cdtt_pkg::DN_W + cdtt_pkg::DAY_HI_W;

  logic [PP_LO_W-1:0] pp_lo_nxt;
  logic [PP_HI_W-1:0] pp_hi_nxt;

  assign pp_lo_nxt = PP_LO_W'(s3_dn_r) * PP_LO_W'(cdtt_pkg::TICKS_DAY_LO);
  assign pp_hi_nxt = PP_HI_W'(s3_dn_r) * PP_HI_W'(cdtt_pkg::TICKS_DAY_HI);

  logic                      s4_date_ok_r, s4_time_ok_r, s4_leap_r;
  logic [cdtt_pkg::DN_W-1:0] s4_dn_r;
  logic [cdtt_pkg::TT_W-1:0] s4_tt_r;
  logic [PP_LO_W-1:0]        s4_pp_lo_r;
  logic [PP_HI_W-1:0]        s4_pp_hi_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_date_ok_r <= s3_date_ok_r;
      s4_time_ok_r <= s3_time_ok_r;
      s4_leap_r    <= s3_leap_r;
      s4_dn_r      <= s3_dn_r;
      s4_tt_r      <= s3_tt_r;
      s4_pp_lo_r   <= pp_lo_nxt;
      s4_pp_hi_r   <= pp_hi_nxt;
    end
  end

  // stage 5: combine partial products into the output register
  logic [cdtt_pkg::DT_W-1:0] dt_nxt;

  assign dt_nxt = cdtt_pkg::DT_W'(s4_pp_lo_r) +
                  (cdtt_pkg::DT_W'(s4_pp_hi_r) << cdtt_pkg::DAY_LO_W);

  logic                      s5_date_ok_r, s5_time_ok_r, s5_leap_r;
  logic [cdtt_pkg::DN_W-1:0] s5_dn_r;
  logic [cdtt_pkg::DT_W-1:0] s5_dt_r;
  logic [cdtt_pkg::TT_W-1:0] s5_tt_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_date_ok_r <= s4_date_ok_r;
      s5_time_ok_r <= s4_time_ok_r;
      s5_leap_r    <= s4_leap_r;
      s5_dn_r      <= s4_dn_r;
      s5_dt_r      <= dt_nxt;
      s5_tt_r      <= s4_tt_r;
    end
  end

  // output word
  assign out_tvalid = s5_vld_r;
  assign out_tdata  = {
    (cdtt_pkg::OUT_DATA_W - cdtt_pkg::DN_W - cdtt_pkg::DT_W - cdtt_pkg::TT_W)'(0),
    s5_tt_r, s5_dt_r, s5_dn_r};
  assign out_tuser  = {s5_leap_r, s5_time_ok_r, s5_date_ok_r};

  // checks
  `CDTT_ASSERT_NOW(a_bad_date_zero, out_tvalid && !out_tuser[0], out_tdata[83:0] == '0, "bad date with nonzero count")
  `CDTT_ASSERT_NOW(a_bad_time_ones, out_tvalid && !out_tuser[1], out_tdata[124:84] == '1, "bad time not all ones")
  `CDTT_ASSERT_NOW(a_day_in_range, out_tvalid && out_tuser[0], out_tdata[21:0] <= cdtt_pkg::DN_W'(cdtt_pkg::MAX_DAY_NUMBER), "day count out of range")
  `CDTT_ASSERT_NOW(a_full_when_blocked, !in_tready, s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && s5_vld_r, "input blocked with a bubble")
  `CDTT_ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && $stable(s5_dn_r) && $stable(s5_tt_r), "stalled word changed")

endmodule
